### rtl/wtp_pkg.sv
// shared types, constants and helpers for the weighted table picker
package wtp_pkg;

  localparam int NUM_SLOTS     = 16;
  localparam int SLOT_BITS     = 4;
  localparam int ID_BITS       = 16;
  localparam int WEIGHT_BITS   = 16;
  localparam int LEVEL_BITS    = 8;
  localparam int TOTAL_BITS    = 20;
  localparam int ROLL_BITS     = 32;
  localparam int SCAN_CNT_BITS = SLOT_BITS + 1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PICK  = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [SLOT_BITS-1:0]    slot;
    logic [ID_BITS-1:0]      entry_id;
    logic [WEIGHT_BITS-1:0]  weight;
    logic [LEVEL_BITS-1:0]   min_level;
    logic [LEVEL_BITS-1:0]   max_level;
    logic signed [ROLL_BITS-1:0] roll;
  } wtp_in_t;

  typedef struct packed {
    logic                    found;
    logic [SLOT_BITS-1:0]    picked_slot;
    logic [ID_BITS-1:0]      picked_id;
    logic [WEIGHT_BITS-1:0]  picked_weight;
    logic [LEVEL_BITS-1:0]   picked_min_level;
    logic [LEVEL_BITS-1:0]   picked_max_level;
    logic [TOTAL_BITS-1:0]   total_weight;
  } wtp_out_t;

  typedef struct packed {
    logic [ID_BITS-1:0]     id;
    logic [WEIGHT_BITS-1:0] weight;
    logic [LEVEL_BITS-1:0]  min_level;
    logic [LEVEL_BITS-1:0]  max_level;
  } wtp_entry_t;

  // controller to datapath
  typedef struct packed {
    logic                 capture;
    logic                 rd_en;
    logic                 rd_sel_slot;
    logic [SLOT_BITS-1:0] scan_addr;
    logic                 wr_en;
    logic                 eval_en;
    logic                 out_load;
  } wtp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic total_zero;
    logic hit;
  } wtp_sts_t;

  function automatic logic is_pickable(wtp_entry_t e);
    is_pickable = (e.id != '0) && (e.weight != '0) && (e.min_level != '0) &&
                  (e.max_level >= e.min_level);
  endfunction

  function automatic logic [TOTAL_BITS-1:0] contrib(wtp_entry_t e);
    contrib = is_pickable(e) ? TOTAL_BITS'(e.weight) : '0;
  endfunction

endpackage

### rtl/wtp_in_if.sv
// request channel: valid, ready and one request beat
interface wtp_in_if;
  logic             valid;
  logic             ready;
  wtp_pkg::wtp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/wtp_out_if.sv
// result channel: valid, ready and one result beat
interface wtp_out_if;
  logic              valid;
  logic              ready;
  wtp_pkg::wtp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/wtp_ctrl.sv
// control state machine: accept, table update, slot scan, result hand-off
module wtp_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_action,
  output logic                          in_ready,
  input  logic                          out_ready,
  output logic                          out_valid,
  output wtp_pkg::wtp_cmd_t             cmd,
  input  wtp_pkg::wtp_sts_t             sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WUPD = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [wtp_pkg::SCAN_CNT_BITS-1:0] scan_cnt;
  logic [wtp_pkg::SCAN_CNT_BITS-1:0] scan_cnt_next;
  logic accept;
  logic scan_more;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign scan_more = (scan_cnt < wtp_pkg::SCAN_CNT_BITS'(wtp_pkg::NUM_SLOTS));

  always_comb begin
    cmd             = '0;
    cmd.capture     = accept;
    cmd.scan_addr   = scan_cnt[wtp_pkg::SLOT_BITS-1:0];
    state_next      = state;
    scan_cnt_next   = scan_cnt;
    case (state)
      S_IDLE: begin
        cmd.rd_en       = accept && (in_action == wtp_pkg::ACT_WRITE);
        cmd.rd_sel_slot = 1'b1;
        scan_cnt_next   = '0;
        if (accept) begin
          if (in_action == wtp_pkg::ACT_WRITE) begin
            state_next = S_WUPD;
          end else if (sts.total_zero) begin
            state_next = S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_WUPD: begin
        cmd.wr_en  = 1'b1;
        state_next = S_FIN;
      end
      S_SCAN: begin
        cmd.rd_en   = scan_more;
        cmd.eval_en = 1'b1;
        if (scan_more) begin
          scan_cnt_next = scan_cnt + 1'b1;
        end
        if (sts.hit) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.out_load = !out_valid || out_ready;
        if (cmd.out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/wtp_dp.sv
// datapath: entry table, pickable total, roll clamp, running sum, result register
module wtp_dp (
  input  logic               clk,
  input  logic               rst,
  input  wtp_pkg::wtp_in_t   in_data,
  input  wtp_pkg::wtp_cmd_t  cmd,
  output wtp_pkg::wtp_sts_t  sts,
  output wtp_pkg::wtp_out_t  out_data
);

  wtp_pkg::wtp_entry_t mem [wtp_pkg::NUM_SLOTS];
  logic [wtp_pkg::NUM_SLOTS-1:0] slot_valid;

  wtp_pkg::wtp_entry_t                rd_data;
  logic                               rd_valid;
  logic [wtp_pkg::SLOT_BITS-1:0]      rd_slot;
  logic [wtp_pkg::SLOT_BITS-1:0]      rd_addr;

  wtp_pkg::wtp_entry_t                new_entry;
  logic [wtp_pkg::SLOT_BITS-1:0]      wr_slot;
  logic [wtp_pkg::TOTAL_BITS-1:0]     total;
  logic [wtp_pkg::TOTAL_BITS-1:0]     total_next;
  logic [wtp_pkg::TOTAL_BITS-1:0]     roll_clamped;
  logic [wtp_pkg::TOTAL_BITS-1:0]     roll_reg;
  logic [wtp_pkg::TOTAL_BITS-1:0]     running;
  logic [wtp_pkg::TOTAL_BITS-1:0]     run_next;
  logic                               eval;

  logic                               found_w;
  logic [wtp_pkg::SLOT_BITS-1:0]      slot_w;
  wtp_pkg::wtp_entry_t                entry_w;

  assign rd_addr = cmd.rd_sel_slot ? in_data.slot : cmd.scan_addr;

  // negative rolls go to zero, rolls at or past the total go to total - 1
  always_comb begin
    if (in_data.roll[wtp_pkg::ROLL_BITS-1]) begin
      roll_clamped = '0;
    end else if (in_data.roll[wtp_pkg::ROLL_BITS-2:0] >=
                 (wtp_pkg::ROLL_BITS-1)'(total)) begin
      roll_clamped = total - 1'b1;
    end else begin
      roll_clamped = in_data.roll[wtp_pkg::TOTAL_BITS-1:0];
    end
  end

  assign total_next = total - wtp_pkg::contrib(rd_data) + wtp_pkg::contrib(new_entry);
  assign run_next   = running + wtp_pkg::TOTAL_BITS'(rd_data.weight);
  assign eval       = cmd.eval_en && rd_valid && wtp_pkg::is_pickable(rd_data);

  assign sts.total_zero = (total == '0);
  assign sts.hit        = eval && (roll_reg < run_next);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= slot_valid[rd_addr] ? mem[rd_addr] : '0;
      rd_slot <= rd_addr;
    end
    if (cmd.wr_en) begin
      mem[wr_slot] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      rd_valid   <= 1'b0;
      total      <= '0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.wr_en) begin
        slot_valid[wr_slot] <= 1'b1;
        total               <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wr_slot             <= in_data.slot;
      new_entry.id        <= in_data.entry_id;
      new_entry.weight    <= in_data.weight;
      new_entry.min_level <= in_data.min_level;
      new_entry.max_level <= in_data.max_level;
      roll_reg            <= roll_clamped;
      running             <= '0;
      found_w             <= 1'b0;
      slot_w              <= '0;
      entry_w             <= '0;
    end else if (eval) begin
      running <= run_next;
      if (sts.hit) begin
        found_w <= 1'b1;
        slot_w  <= rd_slot;
        entry_w <= rd_data;
      end
    end
    if (cmd.out_load) begin
      out_data.found            <= found_w;
      out_data.picked_slot      <= slot_w;
      out_data.picked_id        <= entry_w.id;
      out_data.picked_weight    <= entry_w.weight;
      out_data.picked_min_level <= entry_w.min_level;
      out_data.picked_max_level <= entry_w.max_level;
      out_data.total_weight     <= total;
    end
  end

endmodule

### rtl/weighted_table_picker.sv
// top level of the weighted table picker: controller plus datapath
//
//   channel | dir | beat contents
//   --------+-----+------------------------------------------------------------
//   cmd     | in  | action, slot, entry_id, weight, min_level, max_level, roll
//   res     | out | found, picked_slot/id/weight/min/max_level, total_weight
//
// a write beat runs accept with read of the old entry, table and total
// update, then result hand-off. a pick beat goes from accept straight to the
// hand-off when the total is zero, else the slot scan reads one table entry
// per cycle through the registered read port and stops at the first hit.
// rst (synchronous) clears the state machine, the per-slot valid bits and the
// total, so every slot reads as an empty entry right away.
// a result waiting on res does not block cmd; only the next hand-off waits.
module weighted_table_picker (
  input  logic       clk,
  input  logic       rst,
  wtp_in_if.sink     cmd,
  wtp_out_if.source  res
);

  wtp_pkg::wtp_cmd_t dp_cmd;
  wtp_pkg::wtp_sts_t dp_sts;

  // sequencing: accept, update or scan, then load the output register
  wtp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_action (cmd.data.action),
    .in_ready  (cmd.ready),
    .out_ready (res.ready),
    .out_valid (res.valid),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  // table storage, running total and the result register
  wtp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (cmd.data),
    .cmd      (dp_cmd),
    .sts      (dp_sts),
    .out_data (res.data)
  );

endmodule

### dv/weighted_table_picker_tb.sv
// self-checking testbench for the weighted table picker: directed, back-pressure and random traffic
module weighted_table_picker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // a pick scans at most 16 slots, so the quiet tail after the last result
  // covers anything still in flight
  localparam int TAIL_CYCLES     = 40;
  // longest deliberate receiver hold-off, counted by the receiver process
  localparam int HOLD_CYCLES     = 300;
  // no beat on either channel for this long means the block has hung; the
  // hold-off above is the longest quiet stretch a correct run can show
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int RANDOM_ITEMS    = 1880;
  // the last stretch of random traffic runs with no idling at all
  localparam int CALM_ITEMS      = 300;

  logic clk = 1'b0;
  logic rst;

  wtp_in_if  cmd_if ();
  wtp_out_if res_if ();

  weighted_table_picker DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  always #5 clk = ~clk;

  // predictor copy of the table, updated as each request beat is accepted
  wtp_pkg::wtp_entry_t model_tab[wtp_pkg::NUM_SLOTS];
  // stimulus-side shadow, updated as beats are generated; only steers rolls
  wtp_pkg::wtp_entry_t stim_tab[wtp_pkg::NUM_SLOTS];
  // results owed by the block, oldest first
  wtp_pkg::wtp_out_t   outcome_q[$];

  int  err_count;
  int  res_count;
  int  n_writes;
  int  n_picks;
  int  n_found;
  int  n_empty;
  int  n_clamp_lo;
  int  n_clamp_hi;
  bit  idle_en;
  int  hold_left;

  //--------------------------------------------------------------------------
  // prediction
  //--------------------------------------------------------------------------

  // an entry takes part in the wheel only with an id, a weight, a nonzero
  // min level and a max level that does not fall below the min level
  function automatic bit entry_live(wtp_pkg::wtp_entry_t e);
    return (e.id != '0) && (e.weight != '0) && (e.min_level != '0) &&
           (e.max_level >= e.min_level);
  endfunction

  // 16 x 0xffff still fits in 20 bits, so no wrap can happen here
  function automatic int live_total(input wtp_pkg::wtp_entry_t t[wtp_pkg::NUM_SLOTS]);
    int sum;
    sum = 0;
    for (int i = 0; i < wtp_pkg::NUM_SLOTS; i++)
      if (entry_live(t[i])) sum += int'(t[i].weight);
    return sum;
  endfunction

  // result of one accepted request beat; writes update the predictor table
  function automatic wtp_pkg::wtp_out_t wheel_outcome(wtp_pkg::wtp_in_t b);
    wtp_pkg::wtp_out_t   o;
    longint              total;
    longint              r;
    longint              running;
    wtp_pkg::wtp_entry_t e;
    o = '0;
    if (b.action == wtp_pkg::ACT_WRITE) begin
      e.id        = b.entry_id;
      e.weight    = b.weight;
      e.min_level = b.min_level;
      e.max_level = b.max_level;
      model_tab[b.slot] = e;
      o.total_weight = wtp_pkg::TOTAL_BITS'(live_total(model_tab));
      n_writes++;
      return o;
    end
    n_picks++;
    total = live_total(model_tab);
    o.total_weight = wtp_pkg::TOTAL_BITS'(total);
    // nothing pickable: no entry, all picked fields stay zero
    if (total == 0) begin
      n_empty++;
      return o;
    end
    // negative rolls land on zero, rolls past the end on the last unit
    if (b.roll[wtp_pkg::ROLL_BITS-1]) begin
      r = 0;
      n_clamp_lo++;
    end else begin
      r = longint'(b.roll[wtp_pkg::ROLL_BITS-2:0]);
    end
    if (r > total - 1) begin
      r = total - 1;
      n_clamp_hi++;
    end
    running = 0;
    for (int i = 0; i < wtp_pkg::NUM_SLOTS; i++) begin
      if (entry_live(model_tab[i])) begin
        running += longint'(model_tab[i].weight);
        if (r < running) begin
          o.found            = 1'b1;
          o.picked_slot      = wtp_pkg::SLOT_BITS'(i);
          o.picked_id        = model_tab[i].id;
          o.picked_weight    = model_tab[i].weight;
          o.picked_min_level = model_tab[i].min_level;
          o.picked_max_level = model_tab[i].max_level;
          n_found++;
          break;
        end
      end
    end
    return o;
  endfunction

  //--------------------------------------------------------------------------
  // checking
  //--------------------------------------------------------------------------

  task automatic report_error(string msg);
    err_count++;
    $display("ERROR @%0t result %0d: %s", $time, res_count, msg);
  endtask

  task automatic check_field(string fname, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got 0x%0h want 0x%0h", fname, got, want));
  endtask

  // both channels sampled at the rising edge; the result is checked before
  // the request of the same edge is predicted, since it can only belong to
  // an older request
  always @(posedge clk) begin
    wtp_pkg::wtp_out_t want;
    wtp_pkg::wtp_out_t got;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        res_count++;
        got = res_if.data;
        if (outcome_q.size() == 0) begin
          report_error("result beat with nothing outstanding");
        end else begin
          want = outcome_q.pop_front();
          check_field("found", 32'(got.found), 32'(want.found));
          check_field("picked_slot", 32'(got.picked_slot), 32'(want.picked_slot));
          check_field("picked_id", 32'(got.picked_id), 32'(want.picked_id));
          check_field("picked_weight", 32'(got.picked_weight),
                      32'(want.picked_weight));
          check_field("picked_min_level", 32'(got.picked_min_level),
                      32'(want.picked_min_level));
          check_field("picked_max_level", 32'(got.picked_max_level),
                      32'(want.picked_max_level));
          check_field("total_weight", 32'(got.total_weight),
                      32'(want.total_weight));
        end
      end
      if (cmd_if.valid && cmd_if.ready)
        outcome_q.push_back(wheel_outcome(cmd_if.data));
    end
  end

  //--------------------------------------------------------------------------
  // result side: ready driven at the falling edge
  //--------------------------------------------------------------------------

  // a hold-off requested through hold_left wins over everything; otherwise
  // random stall bursts while idling is enabled, else always ready
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  //--------------------------------------------------------------------------
  // request side
  //--------------------------------------------------------------------------

  // offers one beat and returns right after the edge that accepts it; valid
  // stays high so that back-to-back beats need no extra assignment
  task automatic send_beat(input wtp_pkg::wtp_in_t b);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= b;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // sender goes quiet until every owed result has come back
  task automatic settle();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // write beat; the roll is unused, so it carries random bits
  function automatic wtp_pkg::wtp_in_t write_beat(int s, int id, int w, int mn, int mx);
    wtp_pkg::wtp_in_t b;
    b.action    = wtp_pkg::ACT_WRITE;
    b.slot      = wtp_pkg::SLOT_BITS'(s);
    b.entry_id  = wtp_pkg::ID_BITS'(id);
    b.weight    = wtp_pkg::WEIGHT_BITS'(w);
    b.min_level = wtp_pkg::LEVEL_BITS'(mn);
    b.max_level = wtp_pkg::LEVEL_BITS'(mx);
    b.roll      = $urandom();
    stim_tab[s] = '{id: b.entry_id, weight: b.weight,
                    min_level: b.min_level, max_level: b.max_level};
    return b;
  endfunction

  // pick beat; all entry fields are ignored, so they carry random bits
  function automatic wtp_pkg::wtp_in_t pick_beat(logic [31:0] roll);
    wtp_pkg::wtp_in_t b;
    b.action    = wtp_pkg::ACT_PICK;
    b.slot      = wtp_pkg::SLOT_BITS'($urandom());
    b.entry_id  = wtp_pkg::ID_BITS'($urandom());
    b.weight    = wtp_pkg::WEIGHT_BITS'($urandom());
    b.min_level = wtp_pkg::LEVEL_BITS'($urandom());
    b.max_level = wtp_pkg::LEVEL_BITS'($urandom());
    b.roll      = roll;
    return b;
  endfunction

  // live entries get weights from three size classes so that the wheel
  // has both tiny and huge segments; dead entries break one rule or all at once
  function automatic wtp_pkg::wtp_in_t rand_write(int live_pct);
    int id;
    int w;
    int mn;
    int mx;
    id = $urandom_range(1, 65535);
    case ($urandom_range(0, 2))
      0:       w = $urandom_range(1, 16);
      1:       w = $urandom_range(1, 65535);
      default: w = 65535 - $urandom_range(0, 3);
    endcase
    mn = $urandom_range(1, 255);
    mx = $urandom_range(mn, 255);
    if ($urandom_range(1, 100) > live_pct) begin
      case ($urandom_range(0, 4))
        0: id = 0;
        1: w  = 0;
        2: mn = 0;
        3: begin
          mn = $urandom_range(1, 255);
          mx = $urandom_range(0, mn - 1);
        end
        default: begin
          id = 0;
          w  = 0;
          mn = 0;
          mx = 0;
        end
      endcase
    end
    return write_beat($urandom_range(0, wtp_pkg::NUM_SLOTS - 1), id, w, mn, mx);
  endfunction

  // most rolls fall inside the wheel, some right at segment edges, the
  // rest negative or far past the end
  function automatic wtp_pkg::wtp_in_t rand_pick();
    int          total;
    int          acc;
    int          k;
    int          sel;
    logic [31:0] roll;
    total = live_total(stim_tab);
    sel   = $urandom_range(0, 9);
    if (total == 0 || sel == 0) begin
      roll = $urandom();
    end else if (sel == 1) begin
      roll = {1'b1, 31'($urandom())};
    end else if (sel <= 3) begin
      k   = $urandom_range(0, wtp_pkg::NUM_SLOTS - 1);
      acc = 0;
      for (int i = 0; i <= k; i++)
        if (entry_live(stim_tab[i])) acc += int'(stim_tab[i].weight);
      roll = 32'(acc - $urandom_range(0, 1));
    end else begin
      roll = 32'($urandom_range(0, total - 1));
    end
    return pick_beat(roll);
  endfunction

  //--------------------------------------------------------------------------
  // tests
  //--------------------------------------------------------------------------

  // empty wheel first, then two extreme entries and rolls around the ends
  task automatic test_empty_and_extremes();
    send_beat(pick_beat(32'h0000_0000));
    send_beat(pick_beat(32'hFFFF_FFFF));
    send_beat(write_beat(0, 16'hFFFF, 16'hFFFF, 1, 255));
    send_beat(write_beat(15, 1, 1, 255, 255));
    send_beat(pick_beat(32'h8000_0000));  // most negative: clamps to zero
    send_beat(pick_beat(32'h7FFF_FFFF));  // most positive: clamps to the end
    send_beat(pick_beat(32'd65535));      // first unit of the last segment
    send_beat(pick_beat(32'd65534));      // last unit of the first segment
    send_beat(pick_beat(32'd65536));      // exactly the total: clamps down
  endtask

  // one dead entry for each rule, a live entry with max equal to min, then
  // every live entry cleared out again
  task automatic test_unpickable_entries();
    send_beat(write_beat(5, 0, 10, 1, 1));     // no id
    send_beat(write_beat(6, 6, 0, 1, 1));      // no weight
    send_beat(write_beat(7, 7, 10, 0, 5));     // zero min level
    send_beat(write_beat(8, 8, 10, 10, 9));    // max below min
    send_beat(write_beat(9, 9, 10, 20, 20));   // max equal to min is fine
    send_beat(pick_beat(32'd65535));
    send_beat(pick_beat(32'd65544));
    send_beat(pick_beat(32'd65545));
    send_beat(write_beat(0, 0, 0, 0, 0));
    send_beat(pick_beat(32'd0));
    send_beat(write_beat(9, 0, 0, 0, 0));
    send_beat(write_beat(15, 0, 0, 0, 0));
    send_beat(pick_beat(32'd5));               // entries remain, none live
    send_beat(write_beat(3, 16'h5A5A, 16'h8000, 8'h80, 8'h7F));
    send_beat(pick_beat(32'hA5A5_A5A5));
  endtask

  // results held back for a long stretch while the sender keeps offering,
  // so the block backs up onto its input; the beats themselves fill every
  // slot with the largest weight to reach the widest possible total
  task automatic test_backpressure();
    idle_en   = 1'b0;
    hold_left = HOLD_CYCLES;
    for (int s = 0; s < wtp_pkg::NUM_SLOTS; s++)
      send_beat(write_beat(s, $urandom_range(1, 65535), 16'hFFFF, 1, 255));
    send_beat(pick_beat(32'h7FFF_FFFF));
    send_beat(pick_beat(32'd1048559));
    send_beat(pick_beat(32'd1048560));
    send_beat(pick_beat(32'd0));
    repeat (16) send_beat(rand_pick());
    settle();
  endtask

  // random traffic in blocks; each block picks its own write share, share
  // of live entries and idling, and the final stretch runs without idling
  task automatic test_random_traffic(int count);
    int done;
    int blk;
    int live_pct;
    int wr_pct;
    done = 0;
    while (done < count) begin
      blk = $urandom_range(60, 160);
      if (count - done > CALM_ITEMS) begin
        if (blk > count - done - CALM_ITEMS) blk = count - done - CALM_ITEMS;
        idle_en = ($urandom_range(0, 3) != 0);
      end else begin
        blk     = count - done;
        idle_en = 1'b0;
      end
      case ($urandom_range(0, 3))
        0:       live_pct = 10;
        1:       live_pct = 60;
        default: live_pct = 90;
      endcase
      case ($urandom_range(0, 2))
        0:       wr_pct = 20;
        1:       wr_pct = 50;
        default: wr_pct = 80;
      endcase
      repeat (blk) begin
        if ($urandom_range(1, 100) <= wr_pct) send_beat(rand_write(live_pct));
        else send_beat(rand_pick());
      end
      done += blk;
    end
  endtask

  //--------------------------------------------------------------------------
  // watchdog: a long run of cycles with no beat on either channel
  //--------------------------------------------------------------------------

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat for %0d cycles, %0d results owed", quiet,
             outcome_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  //--------------------------------------------------------------------------
  // main sequence
  //--------------------------------------------------------------------------

  initial begin
    rst          = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    res_if.ready = 1'b0;
    idle_en      = 1'b0;
    hold_left    = 0;
    for (int i = 0; i < wtp_pkg::NUM_SLOTS; i++) begin
      model_tab[i] = '0;
      stim_tab[i]  = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_extremes();
    test_unpickable_entries();
    // sender pause: nothing new until the directed results are all back
    settle();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d writes and %0d picks: %0d found, %0d on an empty wheel",
             n_writes, n_picks, n_found, n_empty);
    $display("rolls clamped up from below zero %0d times, down to the end %0d times",
             n_clamp_lo, n_clamp_hi);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
